### rtl/core/rgbhsl_pkg.sv
`default_nettype none

package rgbhsl_pkg;

	// fixed-point formats
	localparam int HUE_FRAC = 6;
	localparam int PCT_FRAC = 7;

	// field widths
	localparam int CH_W  = 8;
	localparam int SUM_W = CH_W + 1;
	localparam int SEC_W = CH_W + 3;
	localparam int HUE_W = 15;
	localparam int PCT_W = 14;

	// divider geometry: quotient is known to stay below 2^QUO_W
	localparam int DEN_W          = CH_W + 1;
	localparam int QUO_W          = 15;
	localparam int NUM_W          = DEN_W + QUO_W;
	localparam int BITS_PER_STAGE = 3;
	localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

	// start to done, in cycles: two front stages, the divider, one output stage
	localparam int PIPE_LATENCY = DIV_STAGES + 3;

	localparam int CH_MAX = (1 << CH_W) - 1;

	// numerator scales, doubled for round-half-up division
	localparam int HUE_NUM_MUL = 2 * 60 * (1 << HUE_FRAC);
	localparam int SAT_NUM_MUL = 2 * 100 * (1 << PCT_FRAC);

	// lightness = round(L_MUL * s / 255), split into whole and remainder parts
	localparam int L_MUL  = 50 * (1 << PCT_FRAC);
	localparam int L_INT  = L_MUL / CH_MAX;
	localparam int L_REM  = L_MUL % CH_MAX;
	localparam int LR_W   = 17;
	localparam int LQ_W   = LR_W + 9;

	localparam logic [HUE_W-1:0] HUE_WRAP = HUE_W'(360 * (1 << HUE_FRAC));
	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100 * (1 << PCT_FRAC));

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             gray;
		logic [PCT_W-1:0] light;
		logic [CH_W-1:0]  alpha;
	} side_t;

	typedef struct packed {
		logic     valid;
		div_req_t hue_req;
		div_req_t sat_req;
		side_t    side;
	} front_t;

endpackage

`default_nettype wire

### rtl/core/rgbhsl_front.sv
`default_nettype none

module rgbhsl_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [rgbhsl_pkg::CH_W-1:0] red,
	input  wire logic [rgbhsl_pkg::CH_W-1:0] green,
	input  wire logic [rgbhsl_pkg::CH_W-1:0] blue,
	input  wire logic [rgbhsl_pkg::CH_W-1:0] alpha,
	output rgbhsl_pkg::front_t             front
);

	logic                          r_max, g_max;
	logic [rgbhsl_pkg::CH_W-1:0]   mx, mn, d;
	logic [rgbhsl_pkg::SUM_W-1:0]  s;
	logic [rgbhsl_pkg::SEC_W-1:0]  r_x, g_x, b_x, d_x, sec;

	logic                          valid_s1;
	logic [rgbhsl_pkg::SEC_W-1:0]  sec_s1;
	logic [rgbhsl_pkg::CH_W-1:0]   d_s1;
	logic [rgbhsl_pkg::SUM_W-1:0]  s_s1;
	logic [rgbhsl_pkg::CH_W-1:0]   alpha_s1;

	logic [rgbhsl_pkg::CH_W-1:0]   sden;
	logic [rgbhsl_pkg::PCT_W-1:0]  u_int;
	logic [rgbhsl_pkg::LR_W-1:0]   u_rem;
	logic [rgbhsl_pkg::LQ_W-1:0]   u_prod;
	logic [rgbhsl_pkg::PCT_W-1:0]  l_sum, l_clip;

	logic                          valid_s2;
	rgbhsl_pkg::div_req_t          hue_req_s2, sat_req_s2;
	rgbhsl_pkg::side_t             side_s2;

	// extrema with red, then green, winning ties for the maximum
	always_comb begin
		r_max = (red >= green) && (red >= blue);
		g_max = !r_max && (green >= blue);
		if (r_max) begin
			mx = red;
		end else if (g_max) begin
			mx = green;
		end else begin
			mx = blue;
		end
		if ((red <= green) && (red <= blue)) begin
			mn = red;
		end else if (green <= blue) begin
			mn = green;
		end else begin
			mn = blue;
		end
		d = mx - mn;
		s = rgbhsl_pkg::SUM_W'(mx) + rgbhsl_pkg::SUM_W'(mn);
	end

	// sector offset plus signed difference, always nonnegative
	always_comb begin
		r_x = rgbhsl_pkg::SEC_W'(red);
		g_x = rgbhsl_pkg::SEC_W'(green);
		b_x = rgbhsl_pkg::SEC_W'(blue);
		d_x = rgbhsl_pkg::SEC_W'(d);
		if (r_max) begin
			if (green < blue) begin
				sec = d_x * rgbhsl_pkg::SEC_W'(6) - (b_x - g_x);
			end else begin
				sec = g_x - b_x;
			end
		end else if (g_max) begin
			sec = d_x * rgbhsl_pkg::SEC_W'(2) + b_x - r_x;
		end else begin
			sec = d_x * rgbhsl_pkg::SEC_W'(4) + r_x - g_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sec_s1   <= sec;
		d_s1     <= d;
		s_s1     <= s;
		alpha_s1 <= alpha;
	end

	// saturation denominator: s below mid scale, else its mirror
	always_comb begin
		if (s_s1 < rgbhsl_pkg::SUM_W'(rgbhsl_pkg::CH_MAX)) begin
			sden = s_s1[rgbhsl_pkg::CH_W-1:0];
		end else begin
			sden = rgbhsl_pkg::CH_W'(rgbhsl_pkg::SUM_W'(2 * rgbhsl_pkg::CH_MAX) - s_s1);
		end
	end

	// lightness: whole part plus round(rem * s / 255) via the 257 reciprocal
	always_comb begin
		u_int  = rgbhsl_pkg::PCT_W'(s_s1) * rgbhsl_pkg::PCT_W'(rgbhsl_pkg::L_INT);
		u_rem  = rgbhsl_pkg::LR_W'(s_s1) * rgbhsl_pkg::LR_W'(rgbhsl_pkg::L_REM)
			+ rgbhsl_pkg::LR_W'(rgbhsl_pkg::CH_MAX / 2 + 1);
		u_prod = rgbhsl_pkg::LQ_W'(u_rem) * rgbhsl_pkg::LQ_W'(rgbhsl_pkg::CH_MAX + 2);
		l_sum  = u_int + rgbhsl_pkg::PCT_W'(u_prod >> (2 * rgbhsl_pkg::CH_W));
		l_clip = (l_sum > rgbhsl_pkg::PCT_FULL) ? rgbhsl_pkg::PCT_FULL : l_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// rounding numerators and doubled divisors
	always_ff @(posedge clk) begin
		hue_req_s2.num <= rgbhsl_pkg::NUM_W'(sec_s1)
			* rgbhsl_pkg::NUM_W'(rgbhsl_pkg::HUE_NUM_MUL) + rgbhsl_pkg::NUM_W'(d_s1);
		hue_req_s2.den <= {d_s1, 1'b0};
		sat_req_s2.num <= rgbhsl_pkg::NUM_W'(d_s1)
			* rgbhsl_pkg::NUM_W'(rgbhsl_pkg::SAT_NUM_MUL) + rgbhsl_pkg::NUM_W'(sden);
		sat_req_s2.den <= {sden, 1'b0};
		side_s2.gray   <= (d_s1 == '0);
		side_s2.light  <= l_clip;
		side_s2.alpha  <= alpha_s1;
	end

	assign front.valid   = valid_s2;
	assign front.hue_req = hue_req_s2;
	assign front.sat_req = sat_req_s2;
	assign front.side    = side_s2;

endmodule

`default_nettype wire

### rtl/core/rgbhsl_div.sv
`default_nettype none

module rgbhsl_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire rgbhsl_pkg::div_req_t         req,
	output logic                              out_valid,
	output logic [rgbhsl_pkg::QUO_W-1:0]      quo
);

	typedef struct packed {
		logic [rgbhsl_pkg::DEN_W-1:0] rem;
		logic [rgbhsl_pkg::QUO_W-1:0] low;
		logic [rgbhsl_pkg::QUO_W-1:0] quo;
		logic [rgbhsl_pkg::DEN_W-1:0] den;
	} div_st_t;

	logic    vld_s [rgbhsl_pkg::DIV_STAGES];
	div_st_t div_s [rgbhsl_pkg::DIV_STAGES];
	div_st_t nxt   [rgbhsl_pkg::DIV_STAGES];
	div_st_t init;

	// BITS_PER_STAGE restoring steps, one quotient bit each
	function automatic div_st_t div_iter(input div_st_t x);
		div_st_t                    y;
		logic [rgbhsl_pkg::DEN_W:0] t;
		y = x;
		for (int k = 0; k < rgbhsl_pkg::BITS_PER_STAGE; k++) begin
			t = {y.rem, y.low[rgbhsl_pkg::QUO_W-1]};
			y.low = y.low << 1;
			if (t >= {1'b0, y.den}) begin
				y.rem = rgbhsl_pkg::DEN_W'(t - {1'b0, y.den});
				y.quo = {y.quo[rgbhsl_pkg::QUO_W-2:0], 1'b1};
			end else begin
				y.rem = t[rgbhsl_pkg::DEN_W-1:0];
				y.quo = {y.quo[rgbhsl_pkg::QUO_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	// top numerator bits are already below the divisor
	always_comb begin
		init.rem = req.num[rgbhsl_pkg::NUM_W-1:rgbhsl_pkg::QUO_W];
		init.low = req.num[rgbhsl_pkg::QUO_W-1:0];
		init.quo = '0;
		init.den = req.den;
	end

	always_comb begin
		nxt[0] = div_iter(init);
		for (int i = 1; i < rgbhsl_pkg::DIV_STAGES; i++) begin
			nxt[i] = div_iter(div_s[i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rgbhsl_pkg::DIV_STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < rgbhsl_pkg::DIV_STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < rgbhsl_pkg::DIV_STAGES; i++) begin
			div_s[i] <= nxt[i];
		end
	end

	assign out_valid = vld_s[rgbhsl_pkg::DIV_STAGES-1];
	assign quo       = div_s[rgbhsl_pkg::DIV_STAGES-1].quo;

endmodule

`default_nettype wire

### rtl/core/rgb_to_hsl_converter_unit.sv
`default_nettype none

// rgb to hsl pixel converter
// input transfer: drive red, green, blue, alpha and raise start; the pixel is
// taken at any rising edge where start is high and busy is low. busy stays low,
// so a new pixel can be taken on every clock.
// output transfer: done is high in each cycle that holds a result, with hue, saturation,
// lightness and alpha_out valid in that cycle; results come out in input order.
// hue is in 1/64 degree (0 to below 360), saturation and lightness are percent
// in 1/128 steps; gray pixels give zero hue and saturation.
// pipeline: two front stages (extrema, then numerator setup and lightness),
// five divider stages that each resolve 3 quotient bits of the hue and
// saturation divisions, one output stage.
// throughput: one pixel per clock, set by the fully pipelined dividers.
// reset: arst_n clears every valid bit at once; pixels in flight are dropped and
// no done pulse follows. the receiver cannot stall, so nothing waits inside.
module rgb_to_hsl_converter_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]   red,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]   green,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]   blue,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]   alpha,
	output logic                               done,
	output logic [rgbhsl_pkg::HUE_W-1:0]       hue,
	output logic [rgbhsl_pkg::PCT_W-1:0]       saturation,
	output logic [rgbhsl_pkg::PCT_W-1:0]       lightness,
	output logic [rgbhsl_pkg::CH_W-1:0]        alpha_out
);

	rgbhsl_pkg::front_t                 front;
	logic                               hue_vld, sat_vld;
	logic [rgbhsl_pkg::QUO_W-1:0]       hue_quo, sat_quo;
	rgbhsl_pkg::side_t                  side_s [rgbhsl_pkg::DIV_STAGES];
	logic [rgbhsl_pkg::QUO_W-1:0]       hue_fix;
	logic [rgbhsl_pkg::PCT_W-1:0]       sat_fix;

	logic                               done_s8;
	logic [rgbhsl_pkg::HUE_W-1:0]       hue_s8;
	logic [rgbhsl_pkg::PCT_W-1:0]       sat_s8, light_s8;
	logic [rgbhsl_pkg::CH_W-1:0]        alpha_s8;

	// never stalls
	assign busy = 1'b0;

	rgbhsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.alpha    (alpha),
		.front    (front)
	);

	rgbhsl_div u_hue_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front.valid),
		.req       (front.hue_req),
		.out_valid (hue_vld),
		.quo       (hue_quo)
	);

	rgbhsl_div u_sat_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front.valid),
		.req       (front.sat_req),
		.out_valid (sat_vld),
		.quo       (sat_quo)
	);

	// side data delayed to line up with the quotients
	always_ff @(posedge clk) begin
		side_s[0] <= front.side;
		for (int i = 1; i < rgbhsl_pkg::DIV_STAGES; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	// hue wraps 360 to 0, saturation clipped to full scale
	always_comb begin
		if (hue_quo >= rgbhsl_pkg::QUO_W'(rgbhsl_pkg::HUE_WRAP)) begin
			hue_fix = hue_quo - rgbhsl_pkg::QUO_W'(rgbhsl_pkg::HUE_WRAP);
		end else begin
			hue_fix = hue_quo;
		end
		if (sat_quo > rgbhsl_pkg::QUO_W'(rgbhsl_pkg::PCT_FULL)) begin
			sat_fix = rgbhsl_pkg::PCT_FULL;
		end else begin
			sat_fix = rgbhsl_pkg::PCT_W'(sat_quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s8 <= 1'b0;
		end else begin
			done_s8 <= hue_vld;
		end
	end

	// output stage, gray pixels forced to zero hue and saturation
	always_ff @(posedge clk) begin
		if (side_s[rgbhsl_pkg::DIV_STAGES-1].gray) begin
			hue_s8 <= '0;
			sat_s8 <= '0;
		end else begin
			hue_s8 <= rgbhsl_pkg::HUE_W'(hue_fix);
			sat_s8 <= sat_fix;
		end
		light_s8 <= side_s[rgbhsl_pkg::DIV_STAGES-1].light;
		alpha_s8 <= side_s[rgbhsl_pkg::DIV_STAGES-1].alpha;
	end

	assign done       = done_s8;
	assign hue        = hue_s8;
	assign saturation = sat_s8;
	assign lightness  = light_s8;
	assign alpha_out  = alpha_s8;

	// every accepted pixel yields a result after the pipeline latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(rgbhsl_pkg::PIPE_LATENCY) done)
		else $error("result missing after pipeline latency");

	// both dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		hue_vld == sat_vld)
		else $error("hue and saturation dividers out of step");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> hue < rgbhsl_pkg::HUE_WRAP)
		else $error("hue not wrapped below 360 degrees");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (saturation <= rgbhsl_pkg::PCT_FULL)
			&& (lightness <= rgbhsl_pkg::PCT_FULL))
		else $error("percent field above full scale");

	a_hue_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && (hue != '0) |-> saturation != '0)
		else $error("colored pixel with zero saturation");

endmodule

`default_nettype wire
